### rtl/core/bisd_pkg.sv
// Shared constants, types and the color expansion table of the bitplane image decoder.
`timescale 1ns / 1ps
`default_nettype none

package bisd_pkg;

   localparam int HEADER_BYTES   = 128;
   localparam int ROWS           = 200;
   localparam int BLOCKS_PER_ROW = 20;
   localparam int CHECK_BYTES    = 4;
   localparam int PALETTE_END    = 36;
   localparam int HDR_CNT_W      = $clog2(HEADER_BYTES);
   localparam int PLANES         = 4;
   localparam int PLANE_W        = 16;
   localparam int PAL_ENTRIES    = 16;

   typedef struct packed {
      logic       en;
      logic       second;
      logic [3:0] entry;
      logic [7:0] data;
   } pal_wr_type;

   typedef struct packed {
      logic [PLANES-1:0][PLANE_W-1:0] planes;
      logic [4:0]                     col;
      logic [7:0]                     row;
      logic                           last;
      logic                           bad;
   } block_type;

   typedef struct packed {
      logic busy;
      logic can_load;
   } emit_stat_type;

   function automatic logic [7:0] expand3(input logic [2:0] k);
      logic [7:0] v;
      unique case (k)
         3'd0: v = 8'd0;
         3'd1: v = 8'd36;
         3'd2: v = 8'd72;
         3'd3: v = 8'd109;
         3'd4: v = 8'd145;
         3'd5: v = 8'd182;
         3'd6: v = 8'd218;
         3'd7: v = 8'd255;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/core/bisd_emit.sv
// Palette store and pixel serializer that turns one block of plane words into 16 pixels.
`timescale 1ns / 1ps
`default_nettype none

module bisd_emit
   import bisd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pal_wr_type    pal_wr,
   input  wire logic          load,
   input  wire block_type     blk,
   output      emit_stat_type stat,
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   output      logic [47:0]   rsp_tdata,
   output      logic          rsp_tlast,
   output      logic [1:0]    rsp_tuser
);

   logic [8:0] palette_ff [PAL_ENTRIES];
   logic [8:0] palette_in [PAL_ENTRIES];

   logic                           busy_ff, busy_in;
   logic [3:0]                     z_ff, z_in;
   logic [PLANES-1:0][PLANE_W-1:0] planes_ff, planes_in;
   logic [4:0]                     col_ff, col_in;
   logic [7:0]                     row_ff, row_in;
   logic                           last_ff, last_in;
   logic                           bad_ff, bad_in;

   logic        valid_ff, valid_in;
   logic [47:0] data_ff, data_in;
   logic        tlast_ff, tlast_in;
   logic [1:0]  user_ff, user_in;

   logic       advance;
   logic       finishing;
   logic [3:0] idx;
   logic [8:0] pe;

   assign advance   = busy_ff && (!valid_ff || rsp_tready);
   assign finishing = advance && (z_ff == 4'hF);
   assign stat.busy     = busy_ff;
   assign stat.can_load = !busy_ff || finishing;

   assign idx = {planes_ff[3][PLANE_W-1], planes_ff[2][PLANE_W-1],
                 planes_ff[1][PLANE_W-1], planes_ff[0][PLANE_W-1]};
   assign pe  = palette_ff[idx];

   always_comb begin
      for (int i = 0; i < PAL_ENTRIES; i++) begin
         palette_in[i] = palette_ff[i];
      end
      if (pal_wr.en) begin
         if (pal_wr.second) begin
            palette_in[pal_wr.entry][5:0] = {pal_wr.data[6:4], pal_wr.data[2:0]};
         end else begin
            palette_in[pal_wr.entry][8:6] = pal_wr.data[2:0];
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      z_in      = z_ff;
      planes_in = planes_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      last_in   = last_ff;
      bad_in    = bad_ff;
      valid_in  = valid_ff;
      data_in   = data_ff;
      tlast_in  = tlast_ff;
      user_in   = user_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = {3'b000, expand3(pe[2:0]), expand3(pe[5:3]), expand3(pe[8:6]),
                     idx, row_ff, col_ff, z_ff};
         tlast_in = (z_ff == 4'hF);
         user_in  = {bad_ff, last_ff && (z_ff == 4'hF)};
         for (int p = 0; p < PLANES; p++) begin
            planes_in[p] = {planes_ff[p][PLANE_W-2:0], 1'b0};
         end
         z_in = z_ff + 4'd1;
         if (z_ff == 4'hF) begin
            busy_in = 1'b0;
         end
      end else if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         busy_in   = 1'b1;
         z_in      = 4'd0;
         planes_in = blk.planes;
         col_in    = blk.col;
         row_in    = blk.row;
         last_in   = blk.last;
         bad_in    = blk.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAL_ENTRIES; i++) begin
            palette_ff[i] <= '0;
         end
         busy_ff  <= 1'b0;
         z_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < PAL_ENTRIES; i++) begin
            palette_ff[i] <= palette_in[i];
         end
         busy_ff  <= busy_in;
         z_ff     <= z_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      planes_ff <= planes_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
      bad_ff    <= bad_in;
      data_ff   <= data_in;
      tlast_ff  <= tlast_in;
      user_ff   <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire

### rtl/core/bitplane_image_stream_decoder.sv
// Top level of the four-plane image stream decoder: header parser, byte grouping and output.
`timescale 1ns / 1ps
`default_nettype none

// One byte of the image file enters per transfer on the req channel; every eighth pixel byte
// yields sixteen pixels on the rsp channel, one per cycle while the receiver does not stall.
// Bytes one to seven of a group are taken at once; the eighth waits until the pixel
// serializer has issued the last pixel of the previous block. Header bytes are held while the
// serializer still works on a block, so a new palette never colors pixels of the old image.
// The palette store is cleared by reset and keeps the last palette that a header wrote. A write
// on the csr channel changes header parsing from the next image, or at once at an image start.

module bitplane_image_stream_decoder
   import bisd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] byte_value
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,  // [8:0] pixel_x, [16:9] pixel_y, [20:17] color_index,
                                        // [28:21] red, [36:29] green, [44:37] blue, zero pad
   output      logic        rsp_tlast,  // run_last
   output      logic [1:0]  rsp_tuser,  // [0] frame_end, [1] header_bad
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic        csr_data    // header_present
);

   logic                 hdr_present_ff, hdr_present_in;
   logic                 in_header_ff, in_header_in;
   logic [HDR_CNT_W-1:0] hdr_count_ff, hdr_count_in;
   logic [55:0]          group_ff, group_in;
   logic [2:0]           group_count_ff, group_count_in;
   logic [4:0]           block_col_ff, block_col_in;
   logic [7:0]           row_ff, row_in;
   logic                 check_ff, check_in;

   pal_wr_type           pal_wr;
   block_type            blk;
   emit_stat_type        stat;
   logic                 load;
   logic                 accept;
   logic                 at_start;
   logic [63:0]          all_bytes;
   logic [HDR_CNT_W-1:0] pal_offset;

   assign csr_ready = 1'b1;
   assign req_tready = in_header_ff ? !stat.busy : ((group_count_ff != 3'd7) || stat.can_load);
   assign accept = req_tvalid && req_tready;
   assign at_start = in_header_ff ? (hdr_count_ff == '0)
                   : ((group_count_ff == 3'd0) && (block_col_ff == 5'd0) && (row_ff == 8'd0));
   assign all_bytes  = {group_ff, req_tdata};
   assign pal_offset = hdr_count_ff - HDR_CNT_W'(CHECK_BYTES);

   always_comb begin
      for (int p = 0; p < PLANES; p++) begin
         blk.planes[p] = all_bytes[63 - PLANE_W * p -: PLANE_W];
      end
      blk.col  = block_col_ff;
      blk.row  = row_ff;
      blk.last = (row_ff == 8'(ROWS - 1)) && (block_col_ff == 5'(BLOCKS_PER_ROW - 1));
      blk.bad  = check_ff;
   end

   always_comb begin
      hdr_present_in = hdr_present_ff;
      in_header_in   = in_header_ff;
      hdr_count_in   = hdr_count_ff;
      group_in       = group_ff;
      group_count_in = group_count_ff;
      block_col_in   = block_col_ff;
      row_in         = row_ff;
      check_in       = check_ff;
      load           = 1'b0;
      pal_wr.en      = 1'b0;
      pal_wr.second  = pal_offset[0];
      pal_wr.entry   = pal_offset[4:1];
      pal_wr.data    = req_tdata;
      if (accept) begin
         if (in_header_ff) begin
            if (hdr_count_ff < HDR_CNT_W'(CHECK_BYTES)) begin
               if (req_tdata != 8'd0) begin
                  check_in = 1'b1;
               end
            end else if (hdr_count_ff < HDR_CNT_W'(PALETTE_END)) begin
               pal_wr.en = 1'b1;
            end
            if (hdr_count_ff == HDR_CNT_W'(HEADER_BYTES - 1)) begin
               hdr_count_in = '0;
               in_header_in = 1'b0;
            end else begin
               hdr_count_in = hdr_count_ff + 1'b1;
            end
         end else if (group_count_ff != 3'd7) begin
            group_in       = {group_ff[47:0], req_tdata};
            group_count_in = group_count_ff + 3'd1;
         end else begin
            load           = 1'b1;
            group_count_in = 3'd0;
            if (block_col_ff == 5'(BLOCKS_PER_ROW - 1)) begin
               block_col_in = 5'd0;
               if (row_ff == 8'(ROWS - 1)) begin
                  row_in       = 8'd0;
                  in_header_in = hdr_present_ff;
                  hdr_count_in = '0;
               end else begin
                  row_in = row_ff + 8'd1;
               end
            end else begin
               block_col_in = block_col_ff + 5'd1;
            end
         end
      end
      if (csr_valid) begin
         hdr_present_in = csr_data;
         if (at_start) begin
            in_header_in = csr_data;
            hdr_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_present_ff <= 1'b1;
         in_header_ff   <= 1'b1;
         hdr_count_ff   <= '0;
         group_count_ff <= '0;
         block_col_ff   <= '0;
         row_ff         <= '0;
         check_ff       <= 1'b0;
      end else begin
         hdr_present_ff <= hdr_present_in;
         in_header_ff   <= in_header_in;
         hdr_count_ff   <= hdr_count_in;
         group_count_ff <= group_count_in;
         block_col_ff   <= block_col_in;
         row_ff         <= row_in;
         check_ff       <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   bisd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .pal_wr     (pal_wr),
      .load       (load),
      .blk        (blk),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/core/bisd_checker.sv
// Port-level assertions for the bitplane image decoder, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module bisd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic [1:0]  rsp_tuser
);

   // A stalled result holds its value until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("stalled result changed");

   // The end of a block is exactly the pixel at the last position of the block.
   a_block_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == 4'hF)))
      else $error("block end does not match pixel position");

   // The frame ends only on the end of a block.
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end outside a block end");

   // Within a block the pixels follow each other one column at a time on the same row.
   a_next_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
         |-> rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1
            && rsp_tdata[16:4] == $past(rsp_tdata[16:4]) && rsp_tuser[1] == $past(rsp_tuser[1]))
      else $error("pixel order within a block broken");

endmodule

bind bitplane_image_stream_decoder bisd_checker u_bisd_checker (.*);

`default_nettype wire

### verif/pixel_stream_checker.sv
// Checker for the bitplane image decoder: predicts pixels from input bytes and compares them.
`timescale 1ns / 1ps

module pixel_stream_checker
   import bisd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_data,
   output int               error_count,
   output int               pending,
   output int               pixel_count,
   output int               byte_count,
   output int               frame_count
);

   localparam int SHOW_LIMIT = 40;

   typedef struct packed {
      logic [8:0] x;
      logic [7:0] y;
      logic [3:0] idx;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_last;
      logic       frame_end;
      logic       header_bad;
   } pixel_type;

   pixel_type   expected_pixels[$];
   logic        mode_header;
   logic        in_header;
   logic        check_failed;
   int          header_pos;
   logic [55:0] group_bytes;
   int          group_pos;
   int          block_col;
   int          row_pos;
   logic [8:0]  palette[PAL_ENTRIES];

   function automatic logic [7:0] scale3(input logic [2:0] k);
      return 8'((int'(k) * 255) / 7);
   endfunction

   task automatic report_error(input string msg);
      if (error_count < SHOW_LIMIT)
         $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_error($sformatf("pixel %0d: %s is %0d, expected %0d", pixel_count, name, got,
                                want));
   endtask

   task automatic write_mode(input logic value);
      logic at_start;
      at_start = in_header ? (header_pos == 0) :
                 (group_pos == 0 && block_col == 0 && row_pos == 0);
      mode_header = value;
      if (at_start) begin
         in_header  = value;
         header_pos = 0;
      end
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic [63:0] group;
      logic [3:0]  idx;
      logic [8:0]  entry;
      logic        last_block;
      pixel_type   px;
      int          e;
      if (in_header) begin
         if (header_pos < CHECK_BYTES) begin
            if (b != 8'd0)
               check_failed = 1'b1;
         end else if (header_pos < PALETTE_END) begin
            e = (header_pos - CHECK_BYTES) / 2;
            if (((header_pos - CHECK_BYTES) % 2) == 0) begin
               palette[e][8:6] = b[2:0];
            end else begin
               palette[e][5:3] = b[6:4];
               palette[e][2:0] = b[2:0];
            end
         end
         if (header_pos + 1 >= HEADER_BYTES) begin
            header_pos = 0;
            in_header  = 1'b0;
         end else begin
            header_pos++;
         end
      end else if (group_pos < 7) begin
         group_bytes = {group_bytes[47:0], b};
         group_pos++;
      end else begin
         group       = {group_bytes, b};
         group_bytes = '0;
         group_pos   = 0;
         last_block  = (row_pos + 1 >= ROWS) && (block_col + 1 >= BLOCKS_PER_ROW);
         for (int z = 0; z < 16; z++) begin
            // Plane words sit high to low in the group; bit 15 of each word is the leftmost pixel.
            idx           = {group[15 - z], group[31 - z], group[47 - z], group[63 - z]};
            entry         = palette[idx];
            px.x          = 9'(block_col * 16 + z);
            px.y          = 8'(row_pos);
            px.idx        = idx;
            px.red        = scale3(entry[8:6]);
            px.green      = scale3(entry[5:3]);
            px.blue       = scale3(entry[2:0]);
            px.run_last   = (z == 15);
            px.frame_end  = last_block && (z == 15);
            px.header_bad = check_failed;
            expected_pixels.push_back(px);
         end
         block_col++;
         if (block_col >= BLOCKS_PER_ROW) begin
            block_col = 0;
            row_pos++;
            if (row_pos >= ROWS) begin
               row_pos    = 0;
               in_header  = mode_header;
               header_pos = 0;
            end
         end
      end
   endtask

   task automatic check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         report_error($sformatf("pixel at x %0d y %0d arrived with nothing expected",
                                rsp_tdata[8:0], rsp_tdata[16:9]));
      end else begin
         want = expected_pixels.pop_front();
         check_field("pixel_x", rsp_tdata[8:0], want.x);
         check_field("pixel_y", rsp_tdata[16:9], want.y);
         check_field("color_index", rsp_tdata[20:17], want.idx);
         check_field("red", rsp_tdata[28:21], want.red);
         check_field("green", rsp_tdata[36:29], want.green);
         check_field("blue", rsp_tdata[44:37], want.blue);
         check_field("tdata padding", rsp_tdata[47:45], 0);
         check_field("run_last", rsp_tlast, want.run_last);
         check_field("frame_end", rsp_tuser[0], want.frame_end);
         check_field("header_bad", rsp_tuser[1], want.header_bad);
      end
      if (rsp_tuser[0])
         frame_count++;
      pixel_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_pixels.delete();
         mode_header  = 1'b1;
         in_header    = 1'b1;
         check_failed = 1'b0;
         header_pos   = 0;
         group_bytes  = '0;
         group_pos    = 0;
         block_col    = 0;
         row_pos      = 0;
         for (int i = 0; i < PAL_ENTRIES; i++)
            palette[i] = '0;
         error_count  = 0;
         pixel_count  = 0;
         byte_count   = 0;
         frame_count  = 0;
      end else begin
         if (csr_valid && csr_ready)
            write_mode(csr_data);
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
            byte_count++;
         end
         if (rsp_tvalid && rsp_tready)
            check_pixel();
      end
      pending = expected_pixels.size();
   end

endmodule

### verif/tb.sv
// Top of the bitplane image decoder testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps

module tb;
   import bisd_pkg::*;

   localparam int LIMIT     = 1_000_000;
   localparam int LONG_HOLD = 400;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;

   int   error_count;
   int   pending;
   int   pixel_count;
   int   byte_count;
   int   frame_count;
   int   cycle_count = 0;
   int   tx_gap_pct;
   int   rx_stall_pct;
   int   burst_left;
   int   blocks_sent;
   logic hold_request;

   bitplane_image_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   pixel_stream_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .pending     (pending),
      .pixel_count (pixel_count),
      .byte_count  (byte_count),
      .frame_count (frame_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("Timed out after %0d cycles with %0d pixels outstanding.", cycle_count,
                  pending);
         $display("tb NOT OK");
         $finish;
      end
   end

   // The receiver stalls at random, and once holds off for a long stretch on request.
   initial begin : receiver
      int   stall_left;
      logic held;
      stall_left = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            held = 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(5);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_gap_pct   = tx_pct;
      rx_stall_pct = rx_pct;
   endtask

   task automatic put_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic put_block(input logic [63:0] planes);
      for (int i = 0; i < 8; i++)
         put_byte(planes[63 - 8 * i -: 8]);
      blocks_sent++;
   endtask

   task automatic put_pattern_blocks();
      put_block(64'h0000_0000_0000_0000);
      put_block(64'hFFFF_FFFF_FFFF_FFFF);
      put_block(64'h8001_4002_2004_1008);
      put_block(64'hAAAA_5555_CCCC_0F0F);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_mode(input logic value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'd0;
      csr_valid    = 1'b0;
      csr_data     = 1'b0;
      hold_request = 1'b0;
      burst_left   = 0;
      blocks_sent  = 0;
      set_idling(0, 0);
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Both writes land at the image start, so the image begins with a header.
      write_mode(1'b0);
      write_mode(1'b1);

      // A header with one nonzero check byte and a palette that spans all levels.
      set_idling(15, 15);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h00);
      put_byte(8'h80);
      for (int e = 0; e < PAL_ENTRIES; e++) begin
         put_byte({5'($urandom), 3'(e)});
         put_byte({1'($urandom), 3'(7 - e), 1'($urandom), 3'(3 * e)});
      end
      for (int i = PALETTE_END; i < HEADER_BYTES; i++)
         put_byte(8'($urandom));
      set_idling(0, 0);
      put_pattern_blocks();
      set_idling(20, 25);
      for (int n = 0; n < 30; n++) begin
         if (n == 10)
            hold_request = 1'b1;
         if (n == 20)
            set_idling(35, 40);
         put_block({$urandom, $urandom});
      end

      // This write lands mid-image, so it only changes how the next image starts.
      write_mode(1'b0);
      set_idling(10, 10);
      repeat (3) put_block({$urandom, $urandom});
      repeat (3) put_byte(8'($urandom));

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);

      $display("Decoded %0d bytes into %0d checked pixels, with %0d frame ends seen.",
               byte_count, pixel_count, frame_count);
      $display("Covered a header with a failed check word and a full palette, immediate and");
      $display("deferred mode writes, and a long output stall that backed up the input.");
      if (error_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
